@@ src/rccp_pkg.sv @@
// ----------------------------------------------------------------------------
// rccp_pkg
// Shared types and constants for the raycast column projection block.
// ----------------------------------------------------------------------------
package rccp_pkg;

	localparam int MAP_SIZE_DEF = 256;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] MAX16 = 16'hFFFF;
	localparam logic [25:0] MAX26 = 26'h3FF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLAYER_X   = 3'd0,
		REG_PLAYER_Y   = 3'd1,
		REG_SCREEN_H   = 3'd2,
		REG_TEXTURE_W  = 3'd3,
		REG_TEXTURE_H  = 3'd4
	} cfg_reg_t;

	// sideband of the distance divider
	typedef struct packed {
		logic        side;
		logic [15:0] dir_o;
		logic [3:0]  cval;
		logic        neg;
		logic        dzero;
		logic        mirror;
	} dist_sb_t;

	// sideband of the slice height divider
	typedef struct packed {
		logic        side;
		logic [15:0] wdist;
		logic [15:0] dir_o;
		logic [3:0]  cval;
		logic        mirror;
	} height_sb_t;

	// sideband of the texture step divider
	typedef struct packed {
		logic [9:0]  texx;
		logic [15:0] lh;
		logic [11:0] top;
		logic [11:0] bot;
		logic [15:0] wdist;
		logic [3:0]  cval;
	} step_sb_t;

endpackage

@@ src/rccp_div_cell.sv @@
// ----------------------------------------------------------------------------
// rccp_div_cell
// One restoring division step: shifts in a numerator bit, subtracts the
// divisor when it fits, and registers the result for the next cell.
// ----------------------------------------------------------------------------
module rccp_div_cell #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] in_rem,
	input  logic [NW-1:0] in_nq,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_sb,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] out_rem,
	output logic [NW-1:0] out_nq,
	output logic [DW-1:0] out_den,
	output logic [SW-1:0] out_sb
);
	logic [DW:0]   trial;
	logic          fits;
	logic          v_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] nq_q;
	logic [DW-1:0] den_q;
	logic [SW-1:0] sb_q;

	assign trial    = {in_rem, in_nq[NW-1]};
	assign fits     = trial >= {1'b0, in_den};
	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rem_q <= fits ? DW'(trial - {1'b0, in_den}) : trial[DW-1:0];
			nq_q  <= {in_nq[NW-2:0], fits};
			den_q <= in_den;
			sb_q  <= in_sb;
		end
	end

	assign out_valid = v_q;
	assign out_rem   = rem_q;
	assign out_nq    = nq_q;
	assign out_den   = den_q;
	assign out_sb    = sb_q;

endmodule

@@ src/rccp_div.sv @@
// ----------------------------------------------------------------------------
// rccp_div
// Pipelined unsigned divider: a row of step cells, one quotient bit each.
// ----------------------------------------------------------------------------
module rccp_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SW-1:0] in_sb,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [NW-1:0] out_quo,
	output logic [SW-1:0] out_sb
);
	logic          vld_w [NW+1];
	logic          rdy_w [NW+1];
	logic [DW-1:0] rem_w [NW+1];
	logic [NW-1:0] nq_w  [NW+1];
	logic [DW-1:0] den_w [NW+1];
	logic [SW-1:0] sb_w  [NW+1];

	assign vld_w[0] = in_valid;
	assign in_ready = rdy_w[0];
	assign rem_w[0] = '0;
	assign nq_w[0]  = in_num;
	assign den_w[0] = in_den;
	assign sb_w[0]  = in_sb;

	for (genvar k = 0; k < NW; k++) begin : g_cell
		rccp_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_w[k]),
			.in_ready (rdy_w[k]),
			.in_rem   (rem_w[k]),
			.in_nq    (nq_w[k]),
			.in_den   (den_w[k]),
			.in_sb    (sb_w[k]),
			.out_valid(vld_w[k+1]),
			.out_ready(rdy_w[k+1]),
			.out_rem  (rem_w[k+1]),
			.out_nq   (nq_w[k+1]),
			.out_den  (den_w[k+1]),
			.out_sb   (sb_w[k+1])
		);
	end

	assign rdy_w[NW] = out_ready;
	assign out_valid = vld_w[NW];
	assign out_quo   = nq_w[NW];
	assign out_sb    = sb_w[NW];

endmodule

@@ src/raycast_column_projection.sv @@
// ----------------------------------------------------------------------------
// raycast_column_projection
// Wall column projection for a grid raycaster, one screen column per
// transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Write player position, screen height and texture size on the cfg port
//   while no column is in flight. Send one wall hit per screen column on the
//   s_ channel (hit side in s_tuser); the projected column comes out on the
//   m_ channel in the same order.
// Throughput: one transaction per cycle while m_tready stays high. The three
//   divisions are rows of restoring cells, one quotient bit per cell and
//   cycle, so items follow each other through them without waiting.
// Pipeline: 31 cells for the distance, 21 for the slice height, 27 for the
//   texture step, plus four registers for the slice height and rows, the hit
//   coordinate, the texture column and the output.
// Reset: all pipeline slots empty, configuration at its default values.
// Stall: a held m_tready freezes the output register; the slots behind it
//   keep filling, and s_tready falls once the whole row is full.
// ----------------------------------------------------------------------------
module raycast_column_projection #(
	parameter int MAP_SIZE = rccp_pkg::MAP_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [rccp_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [rccp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// cell_x[7:0], cell_y[15:8], dir_x[31:16], dir_y[47:32], cell_value[51:48]
	input  logic [55:0]                     s_tdata,
	// hit_side[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// wall_distance[15:0], slice_height[31:16], top_row[43:32],
	// bottom_row[55:44], texture_index[59:56], texture_column[69:60],
	// texture_step[95:70], texture_start[121:96]
	output logic [127:0]                    m_tdata
);
	import rccp_pkg::*;

	localparam logic [7:0] MapMask = 8'(MAP_SIZE - 1);

	logic [15:0] px_q, py_q;
	logic [12:0] h_q;
	logic [10:0] tw_q, th_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			h_q  <= 13'd480;
			tw_q <= 11'd64;
			th_q <= 11'd64;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_PLAYER_X:  px_q <= cfg_wdata;
				REG_PLAYER_Y:  py_q <= cfg_wdata;
				REG_SCREEN_H:  h_q  <= cfg_wdata[12:0];
				REG_TEXTURE_W: tw_q <= cfg_wdata[10:0];
				REG_TEXTURE_H: th_q <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	logic [11:0] h2;
	assign h2 = h_q[12:1];

	// input decode
	logic               side;
	logic [7:0]         cxm, cym;
	logic signed [15:0] dx, dy, dsel;
	logic signed [17:0] num;
	logic [16:0]        nabs;
	logic [15:0]        dabs;
	dist_sb_t           d1_sb_in, d1_sb_out;

	assign side = s_tuser;
	assign cxm  = s_tdata[7:0] & MapMask;
	assign cym  = s_tdata[15:8] & MapMask;
	assign dx   = s_tdata[31:16];
	assign dy   = s_tdata[47:32];
	assign dsel = side ? dy : dx;

	always_comb begin
		if (side) begin
			num = $signed({2'b0, cym, 8'b0}) - $signed({2'b0, py_q})
				+ (dy[15] ? 18'sd256 : 18'sd0);
		end else begin
			num = $signed({2'b0, cxm, 8'b0}) - $signed({2'b0, px_q})
				+ (dx[15] ? 18'sd256 : 18'sd0);
		end
	end

	assign nabs = num[17] ? 17'(-num) : num[16:0];
	assign dabs = dsel[15] ? 16'(-dsel) : dsel;

	assign d1_sb_in.side   = side;
	assign d1_sb_in.dir_o  = side ? dx : dy;
	assign d1_sb_in.cval   = s_tdata[51:48];
	assign d1_sb_in.neg    = num[17] ^ dsel[15];
	assign d1_sb_in.dzero  = (dsel == 16'sd0);
	assign d1_sb_in.mirror = side ? dy[15] : (!dx[15] && dx != 16'sd0);

	logic        d1_vld, d1_rdy;
	logic [30:0] q1;

	rccp_div #(.NW(31), .DW(16), .SW($bits(dist_sb_t))) u_div_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_num   ({nabs, 14'b0}),
		.in_den   (dabs),
		.in_sb    (d1_sb_in),
		.out_valid(d1_vld),
		.out_ready(d1_rdy),
		.out_quo  (q1),
		.out_sb   (d1_sb_out)
	);

	logic [15:0] wdist;
	height_sb_t  d2_sb_in, d2_sb_out;

	always_comb begin
		if (d1_sb_out.dzero) begin
			wdist = MAX16;
		end else if (d1_sb_out.neg) begin
			wdist = '0;
		end else if (|q1[30:16]) begin
			wdist = MAX16;
		end else begin
			wdist = q1[15:0];
		end
	end

	assign d2_sb_in.side   = d1_sb_out.side;
	assign d2_sb_in.wdist  = wdist;
	assign d2_sb_in.dir_o  = d1_sb_out.dir_o;
	assign d2_sb_in.cval   = d1_sb_out.cval;
	assign d2_sb_in.mirror = d1_sb_out.mirror;

	logic        d2_vld, d2_rdy;
	logic [20:0] q2;

	rccp_div #(.NW(21), .DW(16), .SW($bits(height_sb_t))) u_div_height (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d1_vld),
		.in_ready (d1_rdy),
		.in_num   ({h_q, 8'b0}),
		.in_den   (wdist),
		.in_sb    (d2_sb_in),
		.out_valid(d2_vld),
		.out_ready(d2_rdy),
		.out_quo  (q2),
		.out_sb   (d2_sb_out)
	);

	// slice height, row clamps and hit product
	logic [15:0]        lh;
	logic [14:0]        lh2;
	logic [16:0]        bot_sum;
	logic [12:0]        bot_full;
	logic [11:0]        top_c, bot_c;
	logic signed [32:0] prod;

	assign lh  = (d2_sb_out.wdist == 16'd0 || |q2[20:16]) ? MAX16 : q2[15:0];
	assign lh2 = lh[15:1];
	assign top_c = ({1'b0, lh2} >= {4'b0, h2}) ? 12'd0 : 12'({4'b0, h2} - {1'b0, lh2});
	assign bot_sum = {2'b0, lh2} + {5'b0, h2};

	always_comb begin
		if (bot_sum >= {4'b0, h_q}) begin
			bot_full = (h_q == 13'd0) ? 13'd0 : 13'(h_q - 13'd1);
		end else begin
			bot_full = bot_sum[12:0];
		end
	end

	assign bot_c = bot_full[12] ? 12'hFFF : bot_full[11:0];
	assign prod  = $signed({1'b0, d2_sb_out.wdist}) * $signed(d2_sb_out.dir_o);

	logic               v_s3;
	logic               rdy_s3, rdy_s4, rdy_s5;
	logic               side_s3, mirror_s3;
	logic [15:0]        lh_s3, dist_s3;
	logic [11:0]        top_s3, bot_s3;
	logic [3:0]         cval_s3;
	logic signed [32:0] prod_s3;

	assign rdy_s3 = !v_s3 || rdy_s4;
	assign d2_rdy = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (d2_vld && rdy_s3) begin
			side_s3   <= d2_sb_out.side;
			mirror_s3 <= d2_sb_out.mirror;
			lh_s3     <= lh;
			dist_s3   <= d2_sb_out.wdist;
			top_s3    <= top_c;
			bot_s3    <= bot_c;
			cval_s3   <= d2_sb_out.cval;
			prod_s3   <= prod;
		end
	end

	// fraction of the hit coordinate along the wall
	logic [15:0] pos_along;
	logic [21:0] frac;

	assign pos_along = side_s3 ? px_q : py_q;
	assign frac      = {pos_along[7:0], 14'b0} + prod_s3[21:0];

	logic        v_s4, mirror_s4;
	logic [21:0] frac_s4;
	logic [15:0] lh_s4, dist_s4;
	logic [11:0] top_s4, bot_s4;
	logic [3:0]  cval_s4;

	assign rdy_s4 = !v_s4 || rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			mirror_s4 <= mirror_s3;
			frac_s4   <= frac;
			lh_s4     <= lh_s3;
			dist_s4   <= dist_s3;
			top_s4    <= top_s3;
			bot_s4    <= bot_s3;
			cval_s4   <= cval_s3;
		end
	end

	// texture column
	logic [32:0] tx_prod;
	logic [10:0] texx_raw, texx_m;
	logic [9:0]  texx_c;

	assign tx_prod  = frac_s4 * tw_q;
	assign texx_raw = tx_prod[32:22];
	assign texx_m   = !mirror_s4 ? texx_raw
		: (tw_q == 11'd0) ? 11'd0 : 11'(tw_q - texx_raw - 11'd1);
	assign texx_c   = texx_m[10] ? 10'h3FF : texx_m[9:0];

	logic        v_s5, d3_rdy;
	step_sb_t    sb_s5, d3_sb_out;

	assign rdy_s5 = !v_s5 || d3_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && rdy_s5) begin
			sb_s5.texx  <= texx_c;
			sb_s5.lh    <= lh_s4;
			sb_s5.top   <= top_s4;
			sb_s5.bot   <= bot_s4;
			sb_s5.wdist <= dist_s4;
			sb_s5.cval  <= cval_s4;
		end
	end

	logic        d3_vld, rdy_out;
	logic [26:0] q3;

	rccp_div #(.NW(27), .DW(16), .SW($bits(step_sb_t))) u_div_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s5),
		.in_ready (d3_rdy),
		.in_num   ({th_q, 16'b0}),
		.in_den   (sb_s5.lh),
		.in_sb    (sb_s5),
		.out_valid(d3_vld),
		.out_ready(rdy_out),
		.out_quo  (q3),
		.out_sb   (d3_sb_out)
	);

	// texture step and start
	logic [25:0] step;
	logic [14:0] lh2_o, sval;
	logic [40:0] ts_prod;
	logic [25:0] tstart;
	logic [3:0]  tidx;

	assign step    = (d3_sb_out.lh == 16'd0 || q3[26]) ? MAX26 : q3[25:0];
	assign lh2_o   = d3_sb_out.lh[15:1];
	assign sval    = (lh2_o > {3'b0, h2}) ? 15'(lh2_o - {3'b0, h2}) : 15'd0;
	assign ts_prod = sval * step;
	assign tstart  = (|ts_prod[40:26]) ? MAX26 : ts_prod[25:0];
	assign tidx    = (d3_sb_out.cval == 4'd0) ? 4'd0 : 4'(d3_sb_out.cval - 4'd1);

	logic         v_out_q;
	logic [127:0] data_out_q;

	assign rdy_out = !v_out_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (rdy_out) begin
			v_out_q <= d3_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (d3_vld && rdy_out) begin
			data_out_q <= {6'b0, tstart, step, d3_sb_out.texx, tidx,
				d3_sb_out.bot, d3_sb_out.top, d3_sb_out.lh, d3_sb_out.wdist};
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = data_out_q;

endmodule

@@ src/rccp_checker.sv @@
// ----------------------------------------------------------------------------
// rccp_checker
// Port-level checks for the raycast column projection block.
// ----------------------------------------------------------------------------
module rccp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	a_rows_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[43:32] <= m_tdata[55:44])
		else $error("top row below bottom row");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:0] == 16'd0 |-> m_tdata[31:16] == 16'hFFFF)
		else $error("zero distance without saturated slice height");

	a_tex_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[59:56] != 4'hF)
		else $error("texture index out of range");

endmodule

bind raycast_column_projection rccp_checker u_rccp_checker (.*);
